/* rtl/core/fixed_point_alu_defines.svh */
// Assertion macros used by the fixed-point ALU back end (fpa_back).
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/fpa_pkg.sv */
// Package for the fixed-point ALU: opcodes, request/response structs, constants.
`default_nettype none
package fpa_pkg;
   localparam int FracBitsDflt = 8;
   localparam int QueueDepth   = 4;
   // divider iterations: 64-bit dividend, one quotient bit per stage
   localparam int DivBits      = 64;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_MIN  = 4'd4, OP_MAX = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7,
      OP_I2F  = 4'd8, OP_F2I = 4'd9
   } op_type;

   typedef struct packed {
      logic [3:0]            req_type;
      logic signed [31:0]    operand_a;
      logic signed [31:0]    operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0]    result;
      logic                  a_greater;
      logic                  a_less;
      logic                  a_equal;
      logic                  div_by_zero;
   } rsp_type;

   // unit class chosen at the front
   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2, CLS_NONE = 2'd3
   } cls_type;

   typedef struct packed {
      cls_type               cls;
      logic [3:0]            op;
      logic signed [31:0]    a;
      logic signed [31:0]    b;
      logic                  gt;
      logic                  lt;
      logic                  eq;
   } work_type;
endpackage
`default_nettype wire

/* rtl/core/fpa_front.sv */
// Front end: registers the request, classifies the opcode, computes compare flags.
`default_nettype none
module fpa_front
   import fpa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire req_type  in_req,
   output work_type      out_work,
   output logic          out_valid
);
   work_type work_ff, work_in;
   logic     valid_ff;

   always_comb begin
      work_in    = '0;
      work_in.op = in_req.req_type;
      work_in.a  = in_req.operand_a;
      work_in.b  = in_req.operand_b;
      work_in.gt = in_req.operand_a > in_req.operand_b;
      work_in.lt = in_req.operand_a < in_req.operand_b;
      work_in.eq = in_req.operand_a == in_req.operand_b;
      unique case (in_req.req_type)
         OP_ADD, OP_SUB, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_I2F, OP_F2I:
            work_in.cls = CLS_SIMPLE;
         OP_MUL:  work_in.cls = CLS_MUL;
         OP_DIV:  work_in.cls = CLS_DIV;
         default: work_in.cls = CLS_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= in_valid;
      work_ff <= work_in;
   end

   assign out_work  = work_ff;
   assign out_valid = valid_ff;
endmodule
`default_nettype wire

/* rtl/core/fpa_queue.sv */
// Short FIFO between front and back end.
`default_nettype none
module fpa_queue
   import fpa_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   input  wire logic     pop,
   output work_type      pop_data,
   output logic          not_empty
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   work_type        mem_ff [Depth];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [AW:0]     cnt_ff;

   function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
      return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= incr(wr_ff);
         if (pop)  rd_ff <= incr(rd_ff);
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data  = mem_ff[rd_ff];
   assign not_empty = cnt_ff != '0;
endmodule
`default_nettype wire

/* rtl/core/fpa_back.sv */
// Back end: pipelined execute (simple ops, 2-stage multiply, 64-stage divider).
`default_nettype none
`include "fixed_point_alu_defines.svh"
module fpa_back
   import fpa_pkg::*;
#(
   parameter int FracBits = FracBitsDflt
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire work_type in_work,
   output logic          rsp_strobe,
   output rsp_type       rsp_data
);
   // Every op takes the divider latency so results leave in order.

   // stage 0: register operands, start multiply
   logic                 v0_ff;
   work_type             w0_ff;
   logic signed [63:0]   prod_ff;
   logic signed [31:0]   simple_ff;

   logic signed [31:0]   simple_in;
   always_comb begin
      case (in_work.op)
         OP_ADD:  simple_in = in_work.a + in_work.b;
         OP_SUB:  simple_in = in_work.a - in_work.b;
         OP_MIN:  simple_in = in_work.lt ? in_work.a : in_work.b;
         OP_MAX:  simple_in = in_work.gt ? in_work.a : in_work.b;
         OP_INC:  simple_in = in_work.a + 32'sd1;
         OP_DEC:  simple_in = in_work.a - 32'sd1;
         OP_I2F:  simple_in = in_work.a <<< FracBits;
         OP_F2I:  simple_in = in_work.a >>> FracBits;
         default: simple_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= in_valid;
      w0_ff     <= in_work;
      prod_ff   <= 64'(in_work.a) * 64'(in_work.b);
      simple_ff <= simple_in;
   end

   // divider pipeline: restoring, one quotient bit per stage, on magnitudes
   typedef struct packed {
      logic        v;
      work_type    w;
      logic [31:0] res;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [31:0] den;
      logic        neg;
   } dstage_type;

   dstage_type st_ff [DivBits+1];
   dstage_type st_in [DivBits+1];

   logic [63:0] num0;
   logic [31:0] den0;
   always_comb begin
      num0 = (64'(signed'(w0_ff.a))) <<< FracBits;
      den0 = w0_ff.b;
      st_in[0].v   = v0_ff;
      st_in[0].w   = w0_ff;
      st_in[0].res = (w0_ff.cls == CLS_MUL) ? 32'(prod_ff >>> FracBits) : simple_ff;
      st_in[0].rem = '0;
      st_in[0].quo = num0[63] ? (~num0 + 64'd1) : num0;
      st_in[0].den = den0[31] ? (~den0 + 32'd1) : den0;
      st_in[0].neg = num0[63] ^ den0[31];
   end

   genvar g;
   generate
      for (g = 1; g <= DivBits; g++) begin : g_div
         logic [64:0] sh;
         logic [64:0] diff;
         always_comb begin
            sh   = {st_ff[g-1].rem, st_ff[g-1].quo[63]};
            diff = sh - {33'd0, st_ff[g-1].den};
            st_in[g] = st_ff[g-1];
            if (!diff[64]) begin
               st_in[g].rem = diff[63:0];
               st_in[g].quo = {st_ff[g-1].quo[62:0], 1'b1};
            end else begin
               st_in[g].rem = sh[63:0];
               st_in[g].quo = {st_ff[g-1].quo[62:0], 1'b0};
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DivBits; i++) begin
         if (reset) st_ff[i].v <= 1'b0;
         else       st_ff[i].v <= (i == 0) ? st_in[0].v : st_in[i].v;
         st_ff[i].w   <= st_in[i].w;
         st_ff[i].res <= st_in[i].res;
         st_ff[i].rem <= st_in[i].rem;
         st_ff[i].quo <= st_in[i].quo;
         st_ff[i].den <= st_in[i].den;
         st_ff[i].neg <= st_in[i].neg;
      end
   end

   // output register
   dstage_type   last;
   logic         dz;
   logic [63:0]  q;
   rsp_type      rsp_in;
   logic         strobe_ff;
   rsp_type      rsp_ff;

   always_comb begin
      last = st_ff[DivBits];
      dz   = (last.w.cls == CLS_DIV) && (last.w.b == '0);
      q    = last.neg ? (~last.quo + 64'd1) : last.quo;
      rsp_in.a_greater   = last.w.gt;
      rsp_in.a_less      = last.w.lt;
      rsp_in.a_equal     = last.w.eq;
      rsp_in.div_by_zero = dz;
      if (dz)                        rsp_in.result = '0;
      else if (last.w.cls == CLS_DIV) rsp_in.result = q[31:0];
      else                           rsp_in.result = last.res;
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= last.v;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `FPA_ASSERT_IMP(a_dz_zero, clock, reset, rsp_strobe && rsp_data.div_by_zero, rsp_data.result == '0, "div by zero result not zero")
   `FPA_ASSERT_IMP(a_flags_onehot, clock, reset, rsp_strobe, $onehot({rsp_data.a_greater, rsp_data.a_less, rsp_data.a_equal}), "compare flags not one-hot")
   `FPA_ASSERT_NEXT(a_strobe_follows, clock, reset, last.v, rsp_strobe, "result strobe lost")
   `FPA_ASSERT_IMP(a_lat_len, clock, reset, $rose(st_ff[1].v), $past(v0_ff, 2), "divider pipe slip")
endmodule
`default_nettype wire

/* rtl/core/fixed_point_alu.sv */
// Top level of the signed fixed-point ALU.
// Request path to rsp_strobe: front register (loads at the accepting edge), queue,
//   execute pipeline (operand stage and the one-bit-per-stage divider), output
//   register.
// Throughput: one request per cycle; busy stays low, the back end never stalls.
// Reset: synchronous active high; clears all valid bits, in-flight work is dropped.
`default_nettype none
module fixed_point_alu
   import fpa_pkg::*;
#(
   parameter int FracBits = FracBitsDflt
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);
   work_type fw, qw;
   logic     fv, qv;

   assign busy = 1'b0;

   fpa_front u_front (
      .clock(clock), .reset(reset), .in_valid(start && !busy), .in_req(req_data),
      .out_work(fw), .out_valid(fv)
   );

   // back end always accepts, so the queue drains each cycle it holds data
   fpa_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset), .push(fv), .push_data(fw),
      .pop(qv), .pop_data(qw), .not_empty(qv)
   );

   fpa_back #(.FracBits(FracBits)) u_back (
      .clock(clock), .reset(reset), .in_valid(qv), .in_work(qw),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire
